/* rtl/latency_histogram_table_macros.svh */
// Assertion macros for the latency histogram table.
`ifndef LATENCY_HISTOGRAM_TABLE_MACROS_SVH
`define LATENCY_HISTOGRAM_TABLE_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define LHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define LHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/lht_pkg.sv */
// Shared constants and types of the latency histogram table.
package lht_pkg;

  localparam int unsigned TableEntriesDef = 32;

  localparam int unsigned TimeW   = 16;
  localparam int unsigned BinW    = 8;
  localparam int unsigned EntCntW = 16;
  localparam int unsigned TotalW  = 6;
  localparam int unsigned SeenW   = 8;
  localparam int unsigned ReqW    = 2;

  localparam int unsigned MicrosPerSec = 1000000;
  localparam int unsigned MicrosPerBin = 10000;
  localparam int unsigned BinScale     = MicrosPerSec / MicrosPerBin;
  localparam int unsigned ScaleW       = $clog2(BinScale + 1);
  localparam int unsigned ProdW        = TimeW + ScaleW;

  localparam int unsigned InDataW  = 4 * TimeW;
  localparam int unsigned OutBitsW = BinW + EntCntW + TotalW + SeenW;
  localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;

  localparam logic [TimeW-1:0] TickRateRst = 16'd32768;
  localparam logic [BinW-1:0]  BinSat      = 8'hFF;

  localparam logic [ReqW-1:0] ReqSample = 2'd0;
  localparam logic [ReqW-1:0] ReqRead   = 2'd1;
  localparam logic [ReqW-1:0] ReqClear  = 2'd2;

  typedef struct packed {
    logic rot;
    logic drop;
    logic wr;
  } cell_op_t;

  typedef struct packed {
    logic            done;
    logic [BinW-1:0] bin;
  } div_res_t;

endpackage

/* rtl/lht_cell.sv */
// One table cell: holds a (bin, count) entry and shifts toward the head.
module lht_cell #(
  parameter int unsigned CNT_W = 6,
  parameter int unsigned IDX   = 0
) (
  input  logic                     clk_i,
  input  lht_pkg::cell_op_t        op_i,
  input  logic [CNT_W-1:0]         len_i,
  input  logic [CNT_W-1:0]         wr_idx_i,
  input  logic [lht_pkg::BinW-1:0] wr_bin_i,
  input  logic [lht_pkg::EntCntW-1:0] wr_cnt_i,
  input  logic [lht_pkg::BinW-1:0] nxt_bin_i,
  input  logic [lht_pkg::EntCntW-1:0] nxt_cnt_i,
  input  logic [lht_pkg::BinW-1:0] wrap_bin_i,
  input  logic [lht_pkg::EntCntW-1:0] wrap_cnt_i,
  output logic [lht_pkg::BinW-1:0] bin_o,
  output logic [lht_pkg::EntCntW-1:0] cnt_o
);
  import lht_pkg::*;

  localparam logic [CNT_W-1:0] Idx = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] Pos = CNT_W'(IDX + 1);

  logic [BinW-1:0]    bin_q, bin_d;
  logic [EntCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    bin_d = bin_q;
    cnt_d = cnt_q;
    priority if (op_i.wr && wr_idx_i == Idx) begin
      bin_d = wr_bin_i;
      cnt_d = wr_cnt_i;
    end else if (op_i.rot && Pos < len_i) begin
      bin_d = nxt_bin_i;
      cnt_d = nxt_cnt_i;
    end else if (op_i.rot && Pos == len_i && !op_i.drop) begin
      bin_d = wrap_bin_i;
      cnt_d = wrap_cnt_i;
    end else begin
      bin_d = bin_q;
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    cnt_q <= cnt_d;
  end

  assign bin_o = bin_q;
  assign cnt_o = cnt_q;

endmodule

/* rtl/lht_chain.sv */
// Row of table cells; cell 0 is the oldest entry and feeds the wrap path.
module lht_chain #(
  parameter int unsigned TABLE_ENTRIES = lht_pkg::TableEntriesDef,
  parameter int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                        clk_i,
  input  lht_pkg::cell_op_t           op_i,
  input  logic [CNT_W-1:0]            len_i,
  input  logic [CNT_W-1:0]            wr_idx_i,
  input  logic [lht_pkg::BinW-1:0]    wr_bin_i,
  input  logic [lht_pkg::EntCntW-1:0] wr_cnt_i,
  output logic [lht_pkg::BinW-1:0]    head_bin_o,
  output logic [lht_pkg::EntCntW-1:0] head_cnt_o
);
  import lht_pkg::*;

  logic [BinW-1:0]    bin_w [TABLE_ENTRIES];
  logic [EntCntW-1:0] cnt_w [TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic [BinW-1:0]    nxt_bin;
    logic [EntCntW-1:0] nxt_cnt;

    if (g == TABLE_ENTRIES - 1) begin : g_end
      assign nxt_bin = bin_w[0];
      assign nxt_cnt = cnt_w[0];
    end else begin : g_mid
      assign nxt_bin = bin_w[g+1];
      assign nxt_cnt = cnt_w[g+1];
    end

    lht_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (op_i),
      .len_i      (len_i),
      .wr_idx_i   (wr_idx_i),
      .wr_bin_i   (wr_bin_i),
      .wr_cnt_i   (wr_cnt_i),
      .nxt_bin_i  (nxt_bin),
      .nxt_cnt_i  (nxt_cnt),
      .wrap_bin_i (bin_w[0]),
      .wrap_cnt_i (cnt_w[0]),
      .bin_o      (bin_w[g]),
      .cnt_o      (cnt_w[g])
    );
  end

  assign head_bin_o = bin_w[0];
  assign head_cnt_o = cnt_w[0];

endmodule

/* rtl/lht_div.sv */
// Bin unit: ticks * 100 / tick_rate, saturated at 255, one quotient bit per cycle.
module lht_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lht_pkg::TimeW-1:0] ticks_i,
  input  logic [lht_pkg::TimeW-1:0] rate_i,
  output lht_pkg::div_res_t         res_o
);
  import lht_pkg::*;

  localparam int unsigned StepW = $clog2(BinW);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_ITER = 3'b100
  } dstate_e;

  dstate_e            dstate_q, dstate_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [BinW-1:0]    quo_q, quo_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               done_q, done_d;
  logic [BinW-1:0]    bin_q, bin_d;

  logic [TimeW:0]     shifted;
  logic               ge;

  assign shifted = {rem_q, quo_q[BinW-1]};
  assign ge      = shifted >= {1'b0, rate_i};

  always_comb begin
    dstate_d = dstate_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    step_d   = step_q;
    done_d   = 1'b0;
    bin_d    = bin_q;
    unique case (dstate_q)
      D_IDLE: begin
        if (start_i) begin
          prod_d   = ProdW'(ticks_i) * ProdW'(BinScale);
          dstate_d = D_MUL;
        end
      end
      D_MUL: begin
        if (rate_i == '0 || {1'b0, prod_q} >= {rate_i, {BinW{1'b0}}}) begin
          done_d   = 1'b1;
          bin_d    = BinSat;
          dstate_d = D_IDLE;
        end else begin
          rem_d    = TimeW'(prod_q[ProdW-1:BinW]);
          quo_d    = prod_q[BinW-1:0];
          step_d   = '0;
          dstate_d = D_ITER;
        end
      end
      D_ITER: begin
        rem_d  = ge ? TimeW'(shifted - {1'b0, rate_i}) : TimeW'(shifted);
        quo_d  = {quo_q[BinW-2:0], ge};
        step_d = StepW'(step_q + 1'b1);
        if (step_q == StepW'(BinW - 1)) begin
          done_d   = 1'b1;
          bin_d    = {quo_q[BinW-2:0], ge};
          dstate_d = D_IDLE;
        end
      end
      default: dstate_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstate_q <= D_IDLE;
      step_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      dstate_q <= dstate_d;
      step_q   <= step_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    bin_q  <= bin_d;
  end

  assign res_o.done = done_q;
  assign res_o.bin  = bin_q;

endmodule

/* rtl/latency_histogram_table.sv */
// Latency histogram table top level: request sequencer, bin unit and cell row.
//
// For a latency sample the bin unit does the multiply, the saturation check
// and eight quotient steps (the quotient steps are skipped when the bin
// saturates), then the entry row rotates once through its used cells to find
// and move the bin, and a final write state puts the tail entry in place
// (unless the table is full and the bin is new). A clear empties the table
// and resets samples_seen. A readout sends N beats, N being the number of
// entries in use (one when the table is empty), one per cycle while the output
// is taken, oldest entry first; the row rotates one cell per beat. A new request
// is taken while the last readout beat still waits in the output register.
`include "latency_histogram_table_macros.svh"

module latency_histogram_table #(
  parameter int unsigned TABLE_ENTRIES = lht_pkg::TableEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lht_pkg::TimeW-1:0]    cfg_wdata_i,     // tick_rate
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // create_time, sent_time, rx_time, now_time
  input  logic [lht_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [lht_pkg::ReqW-1:0]     s_axis_tuser_i,  // req_type
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // entry_bin, entry_count, entry_total, samples_seen, zero pad
  output logic [lht_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);
  import lht_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] Entries = CntW'(TABLE_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_READ  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    used_q, used_d;
  logic [SeenW-1:0]   seen_q, seen_d;
  logic [TimeW-1:0]   tick_rate_q;
  logic               div_start_q, div_start_d;
  logic [CntW-1:0]    step_q, step_d;
  logic [CntW-1:0]    len_q, len_d;
  logic               hit_q, hit_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;

  logic [TimeW-1:0]   ticks_q, ticks_d;
  logic [BinW-1:0]    bin_q, bin_d;
  logic [EntCntW-1:0] hcnt_q, hcnt_d;
  logic [BinW-1:0]    out_bin_q, out_bin_d;
  logic [EntCntW-1:0] out_cnt_q, out_cnt_d;
  logic [TotalW-1:0]  out_total_q, out_total_d;
  logic [SeenW-1:0]   out_seen_q, out_seen_d;

  cell_op_t           op;
  logic [CntW-1:0]    op_len;
  logic [CntW-1:0]    wr_idx;
  logic [BinW-1:0]    wr_bin;
  logic [EntCntW-1:0] wr_cnt;
  logic [BinW-1:0]    head_bin;
  logic [EntCntW-1:0] head_cnt;
  div_res_t           div_res;

  logic               in_fire;
  logic               out_load;
  logic [TimeW-1:0]   t_create, t_sent, t_rx, t_now;

  assign t_create = s_axis_tdata_i[TimeW-1:0];
  assign t_sent   = s_axis_tdata_i[2*TimeW-1:TimeW];
  assign t_rx     = s_axis_tdata_i[3*TimeW-1:2*TimeW];
  assign t_now    = s_axis_tdata_i[4*TimeW-1:3*TimeW];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = !out_valid_q || m_axis_tready_i;

  lht_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .ticks_i (ticks_q),
    .rate_i  (tick_rate_q),
    .res_o   (div_res)
  );

  lht_chain #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CNT_W         (CntW)
  ) u_chain (
    .clk_i      (clk_i),
    .op_i       (op),
    .len_i      (op_len),
    .wr_idx_i   (wr_idx),
    .wr_bin_i   (wr_bin),
    .wr_cnt_i   (wr_cnt),
    .head_bin_o (head_bin),
    .head_cnt_o (head_cnt)
  );

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    seen_d      = seen_q;
    div_start_d = 1'b0;
    step_d      = step_q;
    len_d       = len_q;
    hit_d       = hit_q;
    ticks_d     = ticks_q;
    bin_d       = bin_q;
    hcnt_d      = hcnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_last_d  = out_last_q;
    out_bin_d   = out_bin_q;
    out_cnt_d   = out_cnt_q;
    out_total_d = out_total_q;
    out_seen_d  = out_seen_q;
    op          = '0;
    op_len      = len_q;
    wr_idx      = used_q;
    wr_bin      = bin_q;
    wr_cnt      = EntCntW'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (s_axis_tuser_i)
            ReqSample: begin
              ticks_d     = TimeW'((t_sent - t_create) + (t_now - t_rx));
              seen_d      = SeenW'(seen_q + 1'b1);
              div_start_d = 1'b1;
              state_d     = S_DIV;
            end
            ReqRead: begin
              step_d  = '0;
              state_d = S_READ;
            end
            ReqClear: begin
              used_d = '0;
              seen_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          bin_d   = div_res.bin;
          step_d  = '0;
          len_d   = used_q;
          hit_d   = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (step_q != used_q) begin
          op.rot = 1'b1;
          step_d = CntW'(step_q + 1'b1);
          if (!hit_q && head_bin == bin_q) begin
            op.drop = 1'b1;
            hit_d   = 1'b1;
            hcnt_d  = head_cnt;
            len_d   = CntW'(len_q - 1'b1);
          end
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (hit_q) begin
          op.wr  = 1'b1;
          wr_idx = CntW'(used_q - 1'b1);
          wr_cnt = EntCntW'(hcnt_q + 1'b1);
        end else if (used_q < Entries) begin
          op.wr  = 1'b1;
          used_d = CntW'(used_q + 1'b1);
        end
        state_d = S_IDLE;
      end
      S_READ: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_total_d = TotalW'(used_q);
          out_seen_d  = seen_q;
          if (used_q == '0) begin
            out_bin_d  = '0;
            out_cnt_d  = '0;
            out_last_d = 1'b1;
            state_d    = S_IDLE;
          end else begin
            op.rot     = 1'b1;
            op_len     = used_q;
            out_bin_d  = head_bin;
            out_cnt_d  = head_cnt;
            step_d     = CntW'(step_q + 1'b1);
            out_last_d = (CntW'(step_q + 1'b1) == used_q);
            if (CntW'(step_q + 1'b1) == used_q) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      seen_q      <= '0;
      tick_rate_q <= TickRateRst;
      div_start_q <= 1'b0;
      step_q      <= '0;
      len_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      seen_q      <= seen_d;
      div_start_q <= div_start_d;
      step_q      <= step_d;
      len_q       <= len_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      if (cfg_we_i) begin
        tick_rate_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ticks_q     <= ticks_d;
    bin_q       <= bin_d;
    hcnt_q      <= hcnt_d;
    out_bin_q   <= out_bin_d;
    out_cnt_q   <= out_cnt_d;
    out_total_q <= out_total_d;
    out_seen_q  <= out_seen_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OutDataW'({out_seen_q, out_total_q, out_cnt_q, out_bin_q});

  `LHT_ASSERT(a_used_bound, used_q <= Entries, "entry count above table size")
  `LHT_ASSERT_IMP(a_scan_step, state_q == S_SCAN, step_q <= used_q, "scan past used entries")
  `LHT_ASSERT_IMP(a_hit_len, hit_q && state_q == S_SCAN, (len_q + 1'b1) == used_q,
                  "rotation length not shortened by one after a hit")
  `LHT_ASSERT_IMP(a_read_step, state_q == S_READ && used_q != '0, step_q < used_q,
                  "readout step past used entries")
  `LHT_ASSERT_IMP(a_div_done, div_res.done, state_q == S_DIV, "bin result outside divide wait")

endmodule
